>>> hw/rtl/salc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative cache tag model: policy
// codes, configuration register indexes and the lookup request and response.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int DEF_TOTAL_LINES      = 512;
    localparam int DEF_LINE_OFFSET_BITS = 5;
    localparam int DEF_STAMP_WIDTH      = 32;
    localparam int DEF_ADDR_WIDTH       = 32;

    localparam int WL_W       = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'b1;

    localparam logic [WL_W-1:0] WAYS_LOG2_RESET = 4'd1;

    typedef enum logic [1:0] {
        POL_PLAIN          = 2'd0,
        POL_STORE_NO_ALLOC = 2'd1,
        POL_PF_ALWAYS      = 2'd2,
        POL_PF_ON_FILL     = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        LOOK_MISS = 2'd0,
        LOOK_HIT  = 2'd1,
        LOOK_FILL = 2'd2
    } t_look_res;

    typedef struct packed {
        logic            start;
        logic            may_fill;
        logic [WL_W-1:0] set_bits;
    } t_look_req;

    typedef struct packed {
        logic      done;
        t_look_res res;
    } t_look_rsp;

endpackage
`default_nettype wire

>>> hw/rtl/salc_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salc_mem
// Line memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module salc_mem #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 60
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> hw/rtl/salc_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salc_lookup
// Lookup engine: walks the ways of one set through the line memory, one way
// per clock, compares tags and tracks the oldest stamp, then hits, fills or
// replaces the least recently used way, or reports a miss when it may not fill.
// ----------------------------------------------------------------------------
module salc_lookup
    import salc_pkg::*;
#(
    parameter int TOTAL_LINES = DEF_TOTAL_LINES,
    parameter int TAG_W       = DEF_ADDR_WIDTH - DEF_LINE_OFFSET_BITS,
    parameter int STAMP_W     = DEF_STAMP_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_look_req                        i_req,
    input  wire logic [TAG_W-1:0]                 i_line_addr,
    input  wire logic [STAMP_W-1:0]               i_now,
    output t_look_rsp                             o_rsp,
    output logic      [$clog2(TOTAL_LINES)-1:0]   o_way,
    output logic                                  o_rd_en,
    output logic      [$clog2(TOTAL_LINES)-1:0]   o_rd_addr,
    input  wire logic [TAG_W+STAMP_W:0]           i_rd_data,
    output logic                                  o_wr_en,
    output logic      [$clog2(TOTAL_LINES)-1:0]   o_wr_addr,
    output logic      [TAG_W+STAMP_W:0]           o_wr_data
);

    localparam int IDX_W = $clog2(TOTAL_LINES);
    localparam int LAX_W = TAG_W + IDX_W + 1;
    localparam int MEM_W = TAG_W + STAMP_W + 1;

    typedef enum logic [1:0] {
        L_IDLE = 2'b01,
        L_WALK = 2'b10
    } t_lstate;

    t_lstate            r_state, n_state;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [IDX_W:0]     r_sets, n_sets;
    logic [IDX_W:0]     r_issue_idx, n_issue_idx;
    logic               r_issue_on, n_issue_on;
    logic [IDX_W-1:0]   r_issue_way, n_issue_way;
    logic               r_chk_on, n_chk_on;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0]   r_chk_way, n_chk_way;
    logic               r_may_fill, n_may_fill;
    logic [STAMP_W-1:0] r_now, n_now;
    logic               r_have, n_have;
    logic [STAMP_W-1:0] r_best_stamp, n_best_stamp;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic [IDX_W-1:0]   r_best_way, n_best_way;
    logic               r_done, n_done;
    t_look_res          r_res, n_res;
    logic [IDX_W-1:0]   r_way, n_way;

    logic [LAX_W-1:0]   la_x;
    logic [IDX_W:0]     sets_m1;
    logic [IDX_W:0]     next_idx;
    logic               m_valid;
    logic [TAG_W-1:0]   m_tag;
    logic [STAMP_W-1:0] m_stamp;

    assign la_x    = LAX_W'(i_line_addr);
    assign m_valid = i_rd_data[MEM_W-1];
    assign m_tag   = i_rd_data[MEM_W-2:STAMP_W];
    assign m_stamp = i_rd_data[STAMP_W-1:0];

    assign o_rd_en   = (r_state == L_WALK) && r_issue_on;
    assign o_rd_addr = r_issue_idx[IDX_W-1:0];
    assign o_rsp     = '{done: r_done, res: r_res};
    assign o_way     = r_way;

    always_comb begin
        n_state      = r_state;
        n_tag        = r_tag;
        n_sets       = r_sets;
        n_issue_idx  = r_issue_idx;
        n_issue_on   = r_issue_on;
        n_issue_way  = r_issue_way;
        n_chk_on     = r_chk_on;
        n_chk_idx    = r_chk_idx;
        n_chk_way    = r_chk_way;
        n_may_fill   = r_may_fill;
        n_now        = r_now;
        n_have       = r_have;
        n_best_stamp = r_best_stamp;
        n_best_idx   = r_best_idx;
        n_best_way   = r_best_way;
        n_done       = 1'b0;
        n_res        = LOOK_MISS;
        n_way        = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_chk_idx;
        o_wr_data    = {1'b1, r_tag, r_now};
        sets_m1      = '0;
        next_idx     = r_issue_idx + r_sets;

        unique case (r_state)
            L_IDLE: begin
                if (i_req.start) begin
                    n_sets      = (IDX_W + 1)'(1) << i_req.set_bits;
                    sets_m1     = n_sets - 1'b1;
                    n_issue_idx = {1'b0, la_x[IDX_W-1:0] & sets_m1[IDX_W-1:0]};
                    n_tag       = TAG_W'(la_x >> i_req.set_bits);
                    n_issue_on  = 1'b1;
                    n_issue_way = '0;
                    n_chk_on    = 1'b0;
                    n_have      = 1'b0;
                    n_may_fill  = i_req.may_fill;
                    n_now       = i_now;
                    n_state     = L_WALK;
                end
            end
            L_WALK: begin
                n_chk_on  = r_issue_on;
                n_chk_idx = r_issue_idx[IDX_W-1:0];
                n_chk_way = r_issue_way;
                if (r_issue_on) begin
                    n_issue_idx = next_idx;
                    n_issue_on  = next_idx < (IDX_W + 1)'(TOTAL_LINES);
                    n_issue_way = r_issue_way + 1'b1;
                end
                if (r_chk_on) begin
                    if (m_valid && (!r_have || m_stamp < r_best_stamp)) begin
                        n_have       = 1'b1;
                        n_best_stamp = m_stamp;
                        n_best_idx   = r_chk_idx;
                        n_best_way   = r_chk_way;
                    end
                    priority if (!m_valid && r_may_fill) begin
                        o_wr_en = 1'b1;
                        n_done  = 1'b1;
                        n_res   = LOOK_FILL;
                        n_way   = r_chk_way;
                    end else if (m_valid && m_tag == r_tag) begin
                        o_wr_en = 1'b1;
                        n_done  = 1'b1;
                        n_res   = LOOK_HIT;
                        n_way   = r_chk_way;
                    end else if (!r_issue_on) begin
                        n_done = 1'b1;
                        if (r_may_fill) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = n_best_idx;
                            n_res     = LOOK_FILL;
                            n_way     = n_best_way;
                        end
                    end
                    if (n_done) begin
                        n_state    = L_IDLE;
                        n_chk_on   = 1'b0;
                        n_issue_on = 1'b0;
                    end
                end
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= L_IDLE;
            r_issue_on <= 1'b0;
            r_chk_on   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue_on <= n_issue_on;
            r_chk_on   <= n_chk_on;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag        <= n_tag;
        r_sets       <= n_sets;
        r_issue_idx  <= n_issue_idx;
        r_issue_way  <= n_issue_way;
        r_chk_idx    <= n_chk_idx;
        r_chk_way    <= n_chk_way;
        r_may_fill   <= n_may_fill;
        r_now        <= n_now;
        r_have       <= n_have;
        r_best_stamp <= n_best_stamp;
        r_best_idx   <= n_best_idx;
        r_best_way   <= n_best_way;
        r_res        <= n_res;
        r_way        <= n_way;
    end

endmodule
`default_nettype wire

>>> hw/rtl/set_assoc_lru_cache_tag_model_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_model_core
// Tag model of a set-associative cache with timestamp LRU replacement and
// an optional next-line prefetch, one load or store per item.
// ----------------------------------------------------------------------------
// After reset the block is busy while it clears the valid bits of the line
// memory, one line per cycle. An item is taken when start is high and busy
// is low. The demand lookup reads one way of the set per cycle from the
// single read port of the line memory, over ways = 2^min(ways_log2,
// log2(TOTAL_LINES)) ways; a hit, or an empty way when it may fill, ends it
// early. A prefetch lookup, when the policy asks for one, follows in the
// same way. The result is registered when the last lookup ends and shows
// for one cycle only, marked by o_valid; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_model_core
    import salc_pkg::*;
#(
    parameter int TOTAL_LINES      = DEF_TOTAL_LINES,
    parameter int LINE_OFFSET_BITS = DEF_LINE_OFFSET_BITS,
    parameter int STAMP_WIDTH      = DEF_STAMP_WIDTH,
    parameter int ADDR_WIDTH       = DEF_ADDR_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]             i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]            i_cfg_data,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_req_type,
    input  wire logic [ADDR_WIDTH-1:0]            i_byte_address,
    output logic                                  o_valid,
    output logic                                  o_hit,
    output logic                                  o_demand_filled,
    output logic      [$clog2(TOTAL_LINES)-1:0]   o_demand_way,
    output logic                                  o_prefetch_filled,
    output logic                                  o_prefetch_present
);

    localparam int IDX_W = $clog2(TOTAL_LINES);
    localparam int TL    = $clog2(TOTAL_LINES + 1) - 1;
    localparam int TAG_W = ADDR_WIDTH - LINE_OFFSET_BITS;
    localparam int MEM_W = TAG_W + STAMP_WIDTH + 1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_DEMAND = 4'b0100,
        S_PREF   = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_clr_idx, n_clr_idx;
    logic [WL_W-1:0]      r_ways_log2;
    t_policy              r_policy;
    logic [TAG_W-1:0]     r_line_addr, n_line_addr;
    logic [STAMP_WIDTH-1:0] r_count, n_count;
    logic                 r_out_valid, n_out_valid;
    logic                 r_hit, n_hit;
    logic                 r_dfill, n_dfill;
    logic [IDX_W-1:0]     r_dway, n_dway;
    logic                 r_pfill, n_pfill;
    logic                 r_ppres, n_ppres;

    logic [WL_W-1:0]      eff_wl;
    logic [WL_W-1:0]      set_bits;
    t_look_req            lk_req;
    logic [TAG_W-1:0]     lk_line_addr;
    t_look_rsp            lk_rsp;
    logic [IDX_W-1:0]     lk_way;
    logic                 do_pf;
    logic                 finish;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [MEM_W-1:0]     rd_data;
    logic                 lk_wr_en;
    logic [IDX_W-1:0]     lk_wr_addr;
    logic [MEM_W-1:0]     lk_wr_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [MEM_W-1:0]     wr_data;

    assign eff_wl   = (r_ways_log2 > WL_W'(TL)) ? WL_W'(TL) : r_ways_log2;
    assign set_bits = WL_W'(TL) - eff_wl;
    assign busy     = (r_state != S_IDLE);

    assign wr_en   = (r_state == S_CLEAR) ? 1'b1      : lk_wr_en;
    assign wr_addr = (r_state == S_CLEAR) ? r_clr_idx : lk_wr_addr;
    assign wr_data = (r_state == S_CLEAR) ? '0        : lk_wr_data;

    assign o_valid            = r_out_valid;
    assign o_hit              = r_hit;
    assign o_demand_filled    = r_dfill;
    assign o_demand_way       = r_dway;
    assign o_prefetch_filled  = r_pfill;
    assign o_prefetch_present = r_ppres;

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_line_addr  = r_line_addr;
        n_count      = r_count;
        n_out_valid  = 1'b0;
        n_hit        = r_hit;
        n_dfill      = r_dfill;
        n_dway       = r_dway;
        n_pfill      = r_pfill;
        n_ppres      = r_ppres;
        lk_req       = '{start: 1'b0, may_fill: 1'b1, set_bits: set_bits};
        lk_line_addr = r_line_addr + 1'b1;
        do_pf        = (r_policy == POL_PF_ALWAYS)
                    || (r_policy == POL_PF_ON_FILL && lk_rsp.res == LOOK_FILL);
        finish       = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(TOTAL_LINES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    lk_req.start    = 1'b1;
                    lk_req.may_fill = !(r_policy == POL_STORE_NO_ALLOC && i_req_type);
                    lk_line_addr    = i_byte_address[ADDR_WIDTH-1:LINE_OFFSET_BITS];
                    n_line_addr     = i_byte_address[ADDR_WIDTH-1:LINE_OFFSET_BITS];
                    n_state         = S_DEMAND;
                end
            end
            S_DEMAND: begin
                if (lk_rsp.done) begin
                    n_hit   = (lk_rsp.res == LOOK_HIT);
                    n_dfill = (lk_rsp.res == LOOK_FILL);
                    n_dway  = lk_way;
                    n_pfill = 1'b0;
                    n_ppres = 1'b0;
                    if (do_pf) begin
                        lk_req.start = 1'b1;
                        n_state      = S_PREF;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            S_PREF: begin
                if (lk_rsp.done) begin
                    n_pfill = (lk_rsp.res == LOOK_FILL);
                    n_ppres = (lk_rsp.res == LOOK_HIT);
                    finish  = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        if (finish) begin
            n_out_valid = 1'b1;
            n_state     = S_IDLE;
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_ways_log2 <= WAYS_LOG2_RESET;
            r_policy    <= POL_PLAIN;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WAYS_LOG2) begin
                    r_ways_log2 <= i_cfg_data;
                end else if (i_cfg_index == CFG_POLICY_MODE) begin
                    r_policy <= t_policy'(i_cfg_data[1:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_line_addr <= n_line_addr;
        r_hit       <= n_hit;
        r_dfill     <= n_dfill;
        r_dway      <= n_dway;
        r_pfill     <= n_pfill;
        r_ppres     <= n_ppres;
    end

    salc_lookup #(
        .TOTAL_LINES (TOTAL_LINES),
        .TAG_W       (TAG_W),
        .STAMP_W     (STAMP_WIDTH)
    ) u_lookup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (lk_req),
        .i_line_addr (lk_line_addr),
        .i_now       (r_count),
        .o_rsp       (lk_rsp),
        .o_way       (lk_way),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (lk_wr_en),
        .o_wr_addr   (lk_wr_addr),
        .o_wr_data   (lk_wr_data)
    );

    salc_mem #(
        .DEPTH (TOTAL_LINES),
        .WIDTH (MEM_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the set-associative cache tag model with LRU and prefetch.
// A short directed table walks the geometry and policy extremes, store
// no-allocate, next-line prefetch with wrap at the top of memory and the
// associativity change. Random items with set conflicts and reuse follow in
// segments of random geometry and policy. Each result is checked against
// a tag-state predictor in the testbench or a directed row's expected result.
// ----------------------------------------------------------------------------
module tb;
    import salc_pkg::*;

    localparam int LINES        = DEF_TOTAL_LINES;
    localparam int OFS_BITS     = DEF_LINE_OFFSET_BITS;
    localparam int AW           = DEF_ADDR_WIDTH;
    localparam int SW           = DEF_STAMP_WIDTH;
    localparam int LINES_LOG2   = $clog2(DEF_TOTAL_LINES);
    localparam int LA_W         = AW - OFS_BITS;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SEGMENTS     = 16;
    localparam int SEG_ITEMS    = 36;
    localparam int DIR_COUNT    = 24;
    localparam int TAIL_CYCLES  = 1100;

    typedef struct packed {
        logic                  hit;
        logic                  demand_filled;
        logic [LINES_LOG2-1:0] demand_way;
        logic                  prefetch_filled;
        logic                  prefetch_present;
    } t_cache_result;

    typedef struct packed {
        bit            is_cfg;
        logic [3:0]    wl;
        t_policy       pol;
        logic          is_store;
        logic [AW-1:0] addr;
        bit            typed;
        t_cache_result res;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_WAYS_LOG2;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_req_type = 1'b0;
    logic [AW-1:0]         i_byte_address = '0;
    logic                  o_valid;
    logic                  o_hit;
    logic                  o_demand_filled;
    logic [LINES_LOG2-1:0] o_demand_way;
    logic                  o_prefetch_filled;
    logic                  o_prefetch_present;

    bit                    cl_valid [LINES];
    logic [LA_W-1:0]       cl_tag [LINES];
    logic [SW-1:0]         cl_stamp [LINES];
    logic [SW-1:0]         access_ctr;
    logic [3:0]            cur_ways_log2;
    t_policy               cur_policy;

    t_cache_result         pending_results [$];
    logic [AW-1:0]         recent_addrs [$];
    t_dir_row              dir_rows [DIR_COUNT];
    int                    idle_pct = 17;
    logic [AW-1:0]         region_base = '0;
    int                    fail_count = 0;
    int                    cycle_count = 0;

    set_assoc_lru_cache_tag_model_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_byte_address     (i_byte_address),
        .o_valid            (o_valid),
        .o_hit              (o_hit),
        .o_demand_filled    (o_demand_filled),
        .o_demand_way       (o_demand_way),
        .o_prefetch_filled  (o_prefetch_filled),
        .o_prefetch_present (o_prefetch_present)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Hit on the first valid matching way. If it may fill, fill the first empty way,
    // otherwise replace the oldest stamp with ties going to the lowest way. If it may not fill, miss.
    function automatic t_look_res walk_set(input logic [LA_W-1:0] line_addr,
                                           input int set_bits, input bit may_fill,
                                           input logic [SW-1:0] now,
                                           output logic [LINES_LOG2-1:0] way);
        int              sets;
        int              idx;
        int              w;
        int              best_idx;
        int              best_way;
        bit              have;
        logic [SW-1:0]   best_stamp;
        logic [LA_W-1:0] tag;
        sets = 1 << set_bits;
        idx = int'(line_addr & LA_W'(sets - 1));
        tag = line_addr >> set_bits;
        way = '0;
        w = 0;
        while (idx < LINES) begin
            if (!cl_valid[idx]) begin
                if (may_fill) begin
                    cl_valid[idx] = 1'b1;
                    cl_tag[idx] = tag;
                    cl_stamp[idx] = now;
                    way = LINES_LOG2'(w);
                    return LOOK_FILL;
                end
            end else if (cl_tag[idx] == tag) begin
                cl_stamp[idx] = now;
                way = LINES_LOG2'(w);
                return LOOK_HIT;
            end
            idx += sets;
            w++;
        end
        if (!may_fill)
            return LOOK_MISS;
        have = 1'b0;
        best_stamp = '0;
        best_idx = 0;
        best_way = 0;
        w = 0;
        for (idx = int'(line_addr & LA_W'(sets - 1)); idx < LINES; idx += sets) begin
            if (!have || cl_stamp[idx] < best_stamp) begin
                have = 1'b1;
                best_stamp = cl_stamp[idx];
                best_idx = idx;
                best_way = w;
            end
            w++;
        end
        cl_valid[best_idx] = 1'b1;
        cl_tag[best_idx] = tag;
        cl_stamp[best_idx] = now;
        way = LINES_LOG2'(best_way);
        return LOOK_FILL;
    endfunction

    function automatic t_cache_result predict_access(input logic is_store,
                                                     input logic [AW-1:0] addr);
        t_cache_result         r;
        logic [LA_W-1:0]       line_addr;
        int                    set_bits;
        bit                    may_fill;
        t_look_res             dres;
        t_look_res             pres;
        logic [LINES_LOG2-1:0] dway;
        logic [LINES_LOG2-1:0] pway;
        line_addr = addr[AW-1:OFS_BITS];
        set_bits = LINES_LOG2 - ((int'(cur_ways_log2) > LINES_LOG2) ? LINES_LOG2
                                                                    : int'(cur_ways_log2));
        may_fill = !(cur_policy == POL_STORE_NO_ALLOC && is_store);
        dres = walk_set(line_addr, set_bits, may_fill, access_ctr, dway);
        pres = LOOK_MISS;
        if (cur_policy == POL_PF_ALWAYS || (cur_policy == POL_PF_ON_FILL && dres == LOOK_FILL))
            pres = walk_set(line_addr + LA_W'(1), set_bits, 1'b1, access_ctr, pway);
        if (access_ctr != '1)
            access_ctr = access_ctr + 1'b1;
        r.hit = (dres == LOOK_HIT);
        r.demand_filled = (dres == LOOK_FILL);
        r.demand_way = (dres == LOOK_MISS) ? '0 : dway;
        r.prefetch_filled = (pres == LOOK_FILL);
        r.prefetch_present = (pres == LOOK_HIT);
        return r;
    endfunction

    function automatic logic [AW-1:0] pick_address();
        int            sel;
        logic [AW-1:0] a;
        sel = int'($urandom_range(0, 99));
        if (sel < 35 && recent_addrs.size() > 0) begin
            a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
            a[OFS_BITS-1:0] = OFS_BITS'($urandom);
            if ($urandom_range(0, 3) == 0)
                a = a + AW'(1 << OFS_BITS);
        end else if (sel < 70) begin
            a = region_base + AW'($urandom_range(0, 15) << (LINES_LOG2 + OFS_BITS))
                + AW'($urandom_range(0, 63) << OFS_BITS) + AW'($urandom_range(0, 31));
        end else if (sel < 90) begin
            a = AW'($urandom);
        end else begin
            a = ($urandom_range(0, 1) == 1) ? {AW{1'b1}} : '0;
            a[OFS_BITS:0] = (OFS_BITS + 1)'($urandom);
        end
        return a;
    endfunction

    task automatic issue(input logic is_store, input logic [AW-1:0] addr,
                         input bit typed, input t_cache_result typed_res);
        t_cache_result want;
        int            gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? int'($urandom_range(1, 12)) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= is_store;
        i_byte_address <= addr;
        do @(posedge i_clk); while (busy);
        want = predict_access(is_store, addr);
        pending_results = {pending_results, (typed ? typed_res : want)};
        recent_addrs = {recent_addrs, addr};
        if (recent_addrs.size() > 32)
            void'(recent_addrs.pop_front());
    endtask

    task automatic set_config(input logic [3:0] wl, input t_policy pol);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_WAYS_LOG2;
        i_cfg_data <= CFG_DATA_W'(wl);
        @(posedge i_clk);
        i_cfg_index <= CFG_POLICY_MODE;
        i_cfg_data <= CFG_DATA_W'(pol);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_ways_log2 = wl;
        cur_policy = pol;
    endtask

    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with no item pending");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit expected %0d got %0d", want.hit, o_hit);
                    fail_count++;
                end
                if (o_demand_filled !== want.demand_filled) begin
                    $error("demand_filled expected %0d got %0d", want.demand_filled,
                           o_demand_filled);
                    fail_count++;
                end
                if (o_demand_way !== want.demand_way) begin
                    $error("demand_way expected %0d got %0d", want.demand_way, o_demand_way);
                    fail_count++;
                end
                if (o_prefetch_filled !== want.prefetch_filled) begin
                    $error("prefetch_filled expected %0d got %0d", want.prefetch_filled,
                           o_prefetch_filled);
                    fail_count++;
                end
                if (o_prefetch_present !== want.prefetch_present) begin
                    $error("prefetch_present expected %0d got %0d", want.prefetch_present,
                           o_prefetch_present);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_dir_row   row;
        logic [3:0] wl;
        int         r;
        for (int i = 0; i < LINES; i++) begin
            cl_valid[i] = 1'b0;
            cl_tag[i] = '0;
            cl_stamp[i] = '0;
        end
        access_ctr = '0;
        cur_ways_log2 = WAYS_LOG2_RESET;
        cur_policy = POL_PLAIN;

        dir_rows = '{
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'h0000_0000, 1'b1, '{1'b0, 1'b1, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'h0000_001F, 1'b1, '{1'b1, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'h0000_4000, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'h0000_8000, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b1, 4'd1, POL_STORE_NO_ALLOC, 1'b0, 32'h0, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b1, 32'h0001_0000, 1'b1, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b1, 32'h0000_8004, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'h0001_0000, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b1, 32'h0001_0000, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b1, 4'd15, POL_PF_ALWAYS, 1'b0, 32'h0, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'hFFFF_FFE0, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b1, 32'h0000_0020, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b1, 4'd0, POL_PF_ON_FILL, 1'b0, 32'h0, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'h0000_1000, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'h0000_1010, 1'b1, '{1'b1, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b1, 32'hAAAA_5555, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b1, 4'd9, POL_STORE_NO_ALLOC, 1'b0, 32'h0, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b1, 32'h5555_AAA0, 1'b1, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b1, 4'd9, POL_PF_ON_FILL, 1'b0, 32'h0, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b1, 32'h7FFF_FFE0, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b1, 4'd4, POL_PF_ALWAYS, 1'b0, 32'h0, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'h8000_0000, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}},
            '{1'b0, 4'd0, POL_PLAIN, 1'b0, 32'h8000_0000, 1'b0, '{1'b0, 1'b0, 9'd0, 1'b0, 1'b0}}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block clears its line memory after reset and is busy meanwhile.
        while (!busy) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        for (int i = 0; i < DIR_COUNT; i++) begin
            row = dir_rows[i];
            if (row.is_cfg)
                set_config(row.wl, row.pol);
            else
                issue(row.is_store, row.addr, row.typed, row.res);
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idle_pct = (seg < 6) ? 17 : (seg < 11) ? 82 : 0;
            r = int'($urandom_range(0, 9));
            if (r < 6)
                wl = 4'($urandom_range(0, 4));
            else if (r < 9)
                wl = 4'($urandom_range(5, 7));
            else
                wl = 4'($urandom_range(8, 15));
            set_config(wl, t_policy'($urandom_range(0, 3)));
            region_base = AW'($urandom);
            for (int k = 0; k < SEG_ITEMS; k++)
                issue(1'($urandom_range(0, 1)), pick_address(), 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
